// ===== hdl/rrcs_pkg.sv =====
`timescale 1ns / 1ps

package rrcs_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int NUM_PIECES     = 4;
    localparam int CFG_IDX_BITS   = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CLIP_LEFT   = 3'd0,
        CFG_CLIP_TOP    = 3'd1,
        CFG_CLIP_RIGHT  = 3'd2,
        CFG_CLIP_BOTTOM = 3'd3,
        CFG_OP_MODE     = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        MODE_AND = 1'b0,
        MODE_SUB = 1'b1
    } t_op_mode;

    // control that rides with a set of candidate pieces into the serializer
    typedef struct packed {
        logic [NUM_PIECES-1:0] mask;
        logic                  region_end;
    } t_emit_ctl;

endpackage

// ===== hdl/rect_region_clip_subtract.sv =====
`timescale 1ns / 1ps

// Clips a stream of region rectangles against a programmed clip rectangle,
// keeping the overlap (intersect mode) or cutting the clip area out of each
// rectangle as up to four pieces (subtract mode). A rectangle that gives one
// result or none is taken every cycle while the output is not stalled; one
// that gives several pieces holds the output serializer until its last piece
// is out, as the serializer sends a single output beat per cycle. An input
// beat passes three pipeline stages (normalize, overlap compare, piece build),
// the serializer and the output register.
// Program the clip registers only while the block is empty.
module rect_region_clip_subtract
    import rrcs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [COORD_BITS-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_BITS-1:0]  i_in_left,
    input  logic signed [COORD_BITS-1:0]  i_in_top,
    input  logic signed [COORD_BITS-1:0]  i_in_right,
    input  logic signed [COORD_BITS-1:0]  i_in_bottom,
    input  logic                          i_in_region_end,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_BITS-1:0]  o_out_left,
    output logic signed [COORD_BITS-1:0]  o_out_top,
    output logic signed [COORD_BITS-1:0]  o_out_right,
    output logic signed [COORD_BITS-1:0]  o_out_bottom,
    output logic                          o_piece_valid,
    output logic                          o_last_of_input,
    output logic                          o_region_done
);

    logic signed [COORD_BITS-1:0] r_clip_left, r_clip_top, r_clip_right, r_clip_bottom;
    t_op_mode                     r_op_mode;
    // normalized copy of the clip box
    logic signed [COORD_BITS-1:0] r_cn_l, r_cn_t, r_cn_r, r_cn_b;

    logic                                    f_valid;
    logic                                    f_ready;
    logic [NUM_PIECES-1:0][4*COORD_BITS-1:0] f_pieces;
    t_emit_ctl                               f_ctl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_left   <= '0;
            r_clip_top    <= '0;
            r_clip_right  <= '0;
            r_clip_bottom <= '0;
            r_op_mode     <= MODE_AND;
            r_cn_l        <= '0;
            r_cn_t        <= '0;
            r_cn_r        <= '0;
            r_cn_b        <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CLIP_LEFT:   r_clip_left   <= i_cfg_data;
                    CFG_CLIP_TOP:    r_clip_top    <= i_cfg_data;
                    CFG_CLIP_RIGHT:  r_clip_right  <= i_cfg_data;
                    CFG_CLIP_BOTTOM: r_clip_bottom <= i_cfg_data;
                    CFG_OP_MODE:     r_op_mode     <= t_op_mode'(i_cfg_data[0]);
                    default: ;
                endcase
            end
            r_cn_l <= (r_clip_left > r_clip_right) ? r_clip_right : r_clip_left;
            r_cn_r <= (r_clip_left > r_clip_right) ? r_clip_left  : r_clip_right;
            r_cn_t <= (r_clip_top > r_clip_bottom) ? r_clip_bottom : r_clip_top;
            r_cn_b <= (r_clip_top > r_clip_bottom) ? r_clip_top    : r_clip_bottom;
        end
    end

    rrcs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_left        (i_in_left),
        .i_top         (i_in_top),
        .i_right       (i_in_right),
        .i_bottom      (i_in_bottom),
        .i_region_end  (i_in_region_end),
        .i_clip_left   (r_cn_l),
        .i_clip_top    (r_cn_t),
        .i_clip_right  (r_cn_r),
        .i_clip_bottom (r_cn_b),
        .i_op_mode     (r_op_mode),
        .o_valid       (f_valid),
        .i_ready       (f_ready),
        .o_pieces      (f_pieces),
        .o_ctl         (f_ctl)
    );

    rrcs_emit #(
        .COORD_BITS (COORD_BITS)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (f_valid),
        .o_ready         (f_ready),
        .i_pieces        (f_pieces),
        .i_ctl           (f_ctl),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_left      (o_out_left),
        .o_out_top       (o_out_top),
        .o_out_right     (o_out_right),
        .o_out_bottom    (o_out_bottom),
        .o_piece_valid   (o_piece_valid),
        .o_last_of_input (o_last_of_input),
        .o_region_done   (o_region_done)
    );

endmodule

// ===== hdl/rrcs_front.sv =====
`timescale 1ns / 1ps

module rrcs_front
    import rrcs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic signed [COORD_BITS-1:0]                i_left,
    input  logic signed [COORD_BITS-1:0]                i_top,
    input  logic signed [COORD_BITS-1:0]                i_right,
    input  logic signed [COORD_BITS-1:0]                i_bottom,
    input  logic                                        i_region_end,
    input  logic signed [COORD_BITS-1:0]                i_clip_left,
    input  logic signed [COORD_BITS-1:0]                i_clip_top,
    input  logic signed [COORD_BITS-1:0]                i_clip_right,
    input  logic signed [COORD_BITS-1:0]                i_clip_bottom,
    input  t_op_mode                                    i_op_mode,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output logic [NUM_PIECES-1:0][4*COORD_BITS-1:0]     o_pieces,
    output t_emit_ctl                                   o_ctl
);

    typedef struct packed {
        logic hit;
        logic cut_l;
        logic cut_r;
        logic cut_t;
        logic cut_b;
    } t_cut_flags;

    // stage 1: normalized input box
    logic                         r1_v;
    logic signed [COORD_BITS-1:0] r1_l, r1_t, r1_r, r1_b;
    logic                         r1_end;
    // stage 2: overlap and cut flags
    logic                         r2_v;
    logic signed [COORD_BITS-1:0] r2_l, r2_t, r2_r, r2_b;
    logic signed [COORD_BITS-1:0] r2_ov_l, r2_ov_t, r2_ov_r, r2_ov_b;
    t_cut_flags                   r2_f;
    logic                         r2_end;
    // stage 3: candidate pieces
    logic                                    r3_v;
    logic [NUM_PIECES-1:0][4*COORD_BITS-1:0] r3_pc;
    t_emit_ctl                               r3_ctl;

    logic rdy1, rdy2, rdy3;

    logic signed [COORD_BITS-1:0] n1_l, n1_t, n1_r, n1_b;
    logic signed [COORD_BITS-1:0] n2_ov_l, n2_ov_t, n2_ov_r, n2_ov_b;
    t_cut_flags                   n2_f;
    logic [NUM_PIECES-1:0][4*COORD_BITS-1:0] n3_pc;
    logic [NUM_PIECES-1:0]                   n3_mask;

    assign rdy3    = !r3_v || i_ready;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        n1_l = (i_left > i_right) ? i_right : i_left;
        n1_r = (i_left > i_right) ? i_left  : i_right;
        n1_t = (i_top > i_bottom) ? i_bottom : i_top;
        n1_b = (i_top > i_bottom) ? i_top    : i_bottom;
    end

    always_comb begin
        n2_f.cut_l = r1_l < i_clip_left;
        n2_f.cut_r = r1_r > i_clip_right;
        n2_f.cut_t = r1_t < i_clip_top;
        n2_f.cut_b = r1_b > i_clip_bottom;
        n2_ov_l    = n2_f.cut_l ? i_clip_left   : r1_l;
        n2_ov_r    = n2_f.cut_r ? i_clip_right  : r1_r;
        n2_ov_t    = n2_f.cut_t ? i_clip_top    : r1_t;
        n2_ov_b    = n2_f.cut_b ? i_clip_bottom : r1_b;
        n2_f.hit   = (n2_ov_l < n2_ov_r) && (n2_ov_t < n2_ov_b);
    end

    // order: left strip, right strip, then top and bottom at the narrowed width
    always_comb begin
        n3_pc   = '0;
        n3_mask = '0;
        if (i_op_mode == MODE_AND) begin
            n3_pc[0]   = {r2_ov_l, r2_ov_t, r2_ov_r, r2_ov_b};
            n3_mask[0] = r2_f.hit;
        end else if (!r2_f.hit) begin
            n3_pc[0]   = {r2_l, r2_t, r2_r, r2_b};
            n3_mask[0] = 1'b1;
        end else begin
            n3_pc[0] = {r2_l, r2_t, i_clip_left, r2_b};
            n3_pc[1] = {i_clip_right, r2_t, r2_r, r2_b};
            n3_pc[2] = {r2_ov_l, r2_t, r2_ov_r, i_clip_top};
            n3_pc[3] = {r2_ov_l, i_clip_bottom, r2_ov_r, r2_b};
            n3_mask  = {r2_f.cut_b, r2_f.cut_t, r2_f.cut_r, r2_f.cut_l};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_v <= i_valid;
            end
            if (rdy2) begin
                r2_v <= r1_v;
            end
            if (rdy3) begin
                r3_v <= r2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r1_l   <= n1_l;
            r1_t   <= n1_t;
            r1_r   <= n1_r;
            r1_b   <= n1_b;
            r1_end <= i_region_end;
        end
        if (rdy2 && r1_v) begin
            r2_l    <= r1_l;
            r2_t    <= r1_t;
            r2_r    <= r1_r;
            r2_b    <= r1_b;
            r2_ov_l <= n2_ov_l;
            r2_ov_t <= n2_ov_t;
            r2_ov_r <= n2_ov_r;
            r2_ov_b <= n2_ov_b;
            r2_f    <= n2_f;
            r2_end  <= r1_end;
        end
        if (rdy3 && r2_v) begin
            r3_pc             <= n3_pc;
            r3_ctl.mask       <= n3_mask;
            r3_ctl.region_end <= r2_end;
        end
    end

    assign o_valid  = r3_v;
    assign o_pieces = r3_pc;
    assign o_ctl    = r3_ctl;

`ifndef SYNTHESIS
    // intersect mode never produces more than one piece
    a_and_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && i_op_mode == MODE_AND) |-> $onehot0(r3_ctl.mask))
        else $error("intersect mode produced more than one piece");

    // a stalled stage 3 keeps its beat
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && !i_ready) |=> (r3_v && $stable(r3_ctl)))
        else $error("stage 3 lost a stalled beat");

    // the right strip can only come with an overlap
    a_cut_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_v && i_op_mode == MODE_SUB && n3_mask[1]) |-> r2_f.hit)
        else $error("strip emitted without overlap");
`endif

endmodule

// ===== hdl/rrcs_emit.sv =====
`timescale 1ns / 1ps

module rrcs_emit
    import rrcs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [NUM_PIECES-1:0][4*COORD_BITS-1:0] i_pieces,
    input  t_emit_ctl                               i_ctl,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [COORD_BITS-1:0]            o_out_left,
    output logic signed [COORD_BITS-1:0]            o_out_top,
    output logic signed [COORD_BITS-1:0]            o_out_right,
    output logic signed [COORD_BITS-1:0]            o_out_bottom,
    output logic                                    o_piece_valid,
    output logic                                    o_last_of_input,
    output logic                                    o_region_done
);

    logic                                    r_sv;
    logic [NUM_PIECES-1:0][4*COORD_BITS-1:0] r_pc;
    t_emit_ctl                               r_ctl;

    logic                    r_ov;
    logic [4*COORD_BITS-1:0] r_box;
    logic                    r_pvalid;
    logic                    r_last;
    logic                    r_done;

    logic [NUM_PIECES-1:0]   lowbit;
    logic [NUM_PIECES-1:0]   rem;
    logic [4*COORD_BITS-1:0] sel;
    logic                    have_piece;
    logic                    emit_any;
    logic                    rem_zero;
    logic                    out_ld;
    logic                    fin;

    assign lowbit     = r_ctl.mask & ((~r_ctl.mask) + 1'b1);
    assign rem        = r_ctl.mask & ~lowbit;
    assign rem_zero   = (rem == '0);
    assign have_piece = (r_ctl.mask != '0);
    // an item with no piece still sends a bare beat if it closes a region
    assign emit_any   = have_piece || r_ctl.region_end;
    assign out_ld     = !r_ov || i_out_ready;
    assign fin        = r_sv && (!emit_any || (out_ld && rem_zero));
    assign o_ready    = !r_sv || fin;

    always_comb begin
        sel = '0;
        for (int i = 0; i < NUM_PIECES; i++) begin
            if (lowbit[i]) begin
                sel = sel | r_pc[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_ready) begin
                r_sv <= i_valid;
            end
            if (out_ld) begin
                r_ov <= r_sv && emit_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pc  <= i_pieces;
            r_ctl <= i_ctl;
        end else if (r_sv && emit_any && out_ld) begin
            r_ctl.mask <= rem;
        end
        if (out_ld) begin
            r_box    <= have_piece ? sel : '0;
            r_pvalid <= have_piece;
            r_last   <= rem_zero;
            r_done   <= rem_zero && r_ctl.region_end;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_out_left      = r_box[4*COORD_BITS-1:3*COORD_BITS];
    assign o_out_top       = r_box[3*COORD_BITS-1:2*COORD_BITS];
    assign o_out_right     = r_box[2*COORD_BITS-1:COORD_BITS];
    assign o_out_bottom    = r_box[COORD_BITS-1:0];
    assign o_piece_valid   = r_pvalid;
    assign o_last_of_input = r_last;
    assign o_region_done   = r_done;

`ifndef SYNTHESIS
    a_bare_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_piece_valid) |-> (o_last_of_input && o_region_done))
        else $error("bare beat without region end");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_region_done) |-> o_last_of_input)
        else $error("region done on a beat that is not last");

    // while a non-final piece waits, the rest of its item is still held
    a_rest_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_of_input) |-> (r_sv && r_ctl.mask != '0))
        else $error("remaining pieces lost");
`endif

endmodule

// ===== bench/rect_region_clip_subtract_test.sv =====
`timescale 1ns / 1ps

module rect_region_clip_subtract_test;
    import rrcs_pkg::*;

    localparam int CB           = COORD_BITS_DEF;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_RECTS = 250;

    localparam logic [CFG_IDX_BITS-1:0] SPARE_IDX_LO = CFG_IDX_BITS'(int'(CFG_OP_MODE) + 1);
    localparam logic [CFG_IDX_BITS-1:0] SPARE_IDX_HI = '1;

    typedef logic signed [CB-1:0] coord_t;

    localparam coord_t C_MIN = {1'b1, {(CB-1){1'b0}}};
    localparam coord_t C_MAX = {1'b0, {(CB-1){1'b1}}};

    typedef struct packed {
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
        logic   piece_valid;
        logic   last_of_input;
        logic   region_done;
    } piece_t;

    // Holds the clip setup and the pieces still owed by the block.
    class clip_scoreboard;
        coord_t      clip_l, clip_t, clip_r, clip_b;
        t_op_mode    mode;
        piece_t      owed_pieces[$];
        int unsigned fails;

        function new();
            clip_l = '0;
            clip_t = '0;
            clip_r = '0;
            clip_b = '0;
            mode   = MODE_AND;
            fails  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CB-1:0] data);
            case (idx)
                CFG_CLIP_LEFT:   clip_l = data;
                CFG_CLIP_TOP:    clip_t = data;
                CFG_CLIP_RIGHT:  clip_r = data;
                CFG_CLIP_BOTTOM: clip_b = data;
                CFG_OP_MODE:     mode = t_op_mode'(data[0]);
                default: ;
            endcase
        endfunction

        function void add_piece(coord_t l, coord_t t, coord_t r, coord_t b);
            owed_pieces.push_back('{l, t, r, b, 1'b1, 1'b0, 1'b0});
        endfunction

        function void note_rect(coord_t l, coord_t t, coord_t r, coord_t b, logic end_mark);
            coord_t wl, wt, wr, wb;
            coord_t cl, ct, cr, cbt;
            coord_t ol, ot, orr, ob;
            logic   hit;
            int     before_cnt;
            before_cnt = owed_pieces.size();
            wl  = (l > r) ? r : l;
            wr  = (l > r) ? l : r;
            wt  = (t > b) ? b : t;
            wb  = (t > b) ? t : b;
            cl  = (clip_l > clip_r) ? clip_r : clip_l;
            cr  = (clip_l > clip_r) ? clip_l : clip_r;
            ct  = (clip_t > clip_b) ? clip_b : clip_t;
            cbt = (clip_t > clip_b) ? clip_t : clip_b;
            ol  = (wl > cl) ? wl : cl;
            ot  = (wt > ct) ? wt : ct;
            orr = (wr < cr) ? wr : cr;
            ob  = (wb < cbt) ? wb : cbt;
            hit = (ol < orr) && (ot < ob);
            if (mode == MODE_AND) begin
                if (hit)
                    add_piece(ol, ot, orr, ob);
            end else if (!hit) begin
                add_piece(wl, wt, wr, wb);
            end else begin
                // side strips take full height, top/bottom use what is left
                if (wl < cl) begin
                    add_piece(wl, wt, cl, wb);
                    wl = cl;
                end
                if (wr > cr) begin
                    add_piece(cr, wt, wr, wb);
                    wr = cr;
                end
                if (wt < ct) begin
                    add_piece(wl, wt, wr, ct);
                    wt = ct;
                end
                if (wb > cbt)
                    add_piece(wl, cbt, wr, wb);
            end
            if (owed_pieces.size() == before_cnt) begin
                if (end_mark)
                    owed_pieces.push_back('{'0, '0, '0, '0, 1'b0, 1'b1, 1'b1});
            end else begin
                owed_pieces[owed_pieces.size()-1].last_of_input = 1'b1;
                owed_pieces[owed_pieces.size()-1].region_done   = end_mark;
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_piece(piece_t got);
            piece_t want;
            if (owed_pieces.size() == 0) begin
                $error("result beat with nothing owed: %0d %0d %0d %0d pv=%0b",
                       got.left, got.top, got.right, got.bottom, got.piece_valid);
                fails++;
                return;
            end
            want = owed_pieces.pop_front();
            compare_field("out_left", want.left, got.left);
            compare_field("out_top", want.top, got.top);
            compare_field("out_right", want.right, got.right);
            compare_field("out_bottom", want.bottom, got.bottom);
            compare_field("piece_valid", want.piece_valid, got.piece_valid);
            compare_field("last_of_input", want.last_of_input, got.last_of_input);
            compare_field("region_done", want.region_done, got.region_done);
        endfunction

        function int unsigned pending();
            return owed_pieces.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [CB-1:0]           i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    coord_t                  i_in_left;
    coord_t                  i_in_top;
    coord_t                  i_in_right;
    coord_t                  i_in_bottom;
    logic                    i_in_region_end;
    logic                    o_out_valid;
    logic                    i_out_ready;
    coord_t                  o_out_left;
    coord_t                  o_out_top;
    coord_t                  o_out_right;
    coord_t                  o_out_bottom;
    logic                    o_piece_valid;
    logic                    o_last_of_input;
    logic                    o_region_done;

    clip_scoreboard sb = new();
    int unsigned    quiet_cycles = 0;
    bit             steady = 1'b0;

    rect_region_clip_subtract #(
        .COORD_BITS(CB)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_left       (i_in_left),
        .i_in_top        (i_in_top),
        .i_in_right      (i_in_right),
        .i_in_bottom     (i_in_bottom),
        .i_in_region_end (i_in_region_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_left      (o_out_left),
        .o_out_top       (o_out_top),
        .o_out_right     (o_out_right),
        .o_out_bottom    (o_out_bottom),
        .o_piece_valid   (o_piece_valid),
        .o_last_of_input (o_last_of_input),
        .o_region_done   (o_region_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one; none in steady phases
    function automatic int unsigned idle_len();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // values clustered around the clip edges so every strip combination shows up
    function automatic coord_t pick_coord(coord_t lo, coord_t hi);
        int base;
        base = ($urandom_range(0, 1) != 0) ? int'(lo) : int'(hi);
        case ($urandom_range(0, 9))
            0, 1: return coord_t'($urandom);
            2: return ($urandom_range(0, 1) != 0) ? C_MIN : C_MAX;
            3: return lo;
            4: return hi;
            default: return coord_t'(base + int'($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.note_rect(i_in_left, i_in_top, i_in_right, i_in_bottom, i_in_region_end);
            if (o_out_valid && i_out_ready)
                sb.check_piece('{o_out_left, o_out_top, o_out_right, o_out_bottom,
                                 o_piece_valid, o_last_of_input, o_region_done});
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int unsigned gap;
        forever begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            gap = idle_len();
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // valid stays up after the beat; only a gap lowers it
    task automatic send_rect(coord_t l, coord_t t, coord_t r, coord_t b, logic end_mark);
        int unsigned gap;
        i_in_valid      <= 1'b1;
        i_in_left       <= l;
        i_in_top        <= t;
        i_in_right      <= r;
        i_in_bottom     <= b;
        i_in_region_end <= end_mark;
        do @(posedge i_clk); while (!o_in_ready);
        gap = idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic program_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CB-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(coord_t l, coord_t t, coord_t r, coord_t b, t_op_mode m);
        logic [CB-1:0] mode_word;
        if ($urandom_range(0, 3) == 0)
            program_reg(CFG_IDX_BITS'($urandom_range(SPARE_IDX_LO, SPARE_IDX_HI)),
                        CB'($urandom));
        program_reg(CFG_CLIP_LEFT, l);
        program_reg(CFG_CLIP_TOP, t);
        program_reg(CFG_CLIP_RIGHT, r);
        program_reg(CFG_CLIP_BOTTOM, b);
        // upper bits of the mode word are junk, only bit 0 counts
        mode_word    = CB'($urandom);
        mode_word[0] = m;
        program_reg(CFG_OP_MODE, mode_word);
        i_cfg_valid <= 1'b0;
    endtask

    // drain: all owed pieces out, then room for rects that give no beat
    task automatic settle();
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned sent;
        int unsigned n;
        int          cx, cy, w, h;
        coord_t      kl, kt, kr, kb;
        coord_t      sw;

        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_CLIP_LEFT;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_in_left       <= '0;
        i_in_top        <= '0;
        i_in_right      <= '0;
        i_in_bottom     <= '0;
        i_in_region_end <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setup: empty clip in AND mode, so only bare end marks come out
        send_rect(-10, -10, 10, 10, 1'b1);
        send_rect(5, 5, 20, 20, 1'b0);
        settle();

        // clip given with swapped edges
        configure(100, 50, -100, -50, MODE_AND);
        send_rect(C_MIN, C_MIN, C_MAX, C_MAX, 1'b0);
        send_rect(C_MAX, C_MAX, C_MIN, C_MIN, 1'b1);
        send_rect(150, -20, 50, 80, 1'b0);
        send_rect(100, -50, 200, 50, 1'b1);
        send_rect(0, 0, 0, 30, 1'b0);
        settle();

        configure(-100, -50, 100, 50, MODE_SUB);
        send_rect(C_MIN, C_MIN, C_MAX, C_MAX, 1'b1);
        send_rect(-10, -10, 10, 10, 1'b0);
        send_rect(-10, -10, 10, 10, 1'b1);
        send_rect(-200, -10, 10, 10, 1'b0);
        send_rect(10, 10, 300, 20, 1'b0);
        send_rect(-10, -80, 10, 10, 1'b0);
        send_rect(-10, 10, 10, 90, 1'b1);
        send_rect(300, 300, 200, 200, 1'b0);
        send_rect(40, 40, 40, 60, 1'b1);
        send_rect(-100, -50, 100, 50, 1'b0);
        settle();

        // clip spans the whole plane
        configure(C_MAX, C_MAX, C_MIN, C_MIN, MODE_SUB);
        send_rect(C_MIN, C_MIN, C_MAX, C_MAX, 1'b1);
        send_rect(C_MAX, 0, C_MIN, 5, 1'b0);
        settle();
        configure(C_MIN, C_MIN, C_MAX, C_MAX, MODE_AND);
        send_rect(-1, C_MAX, C_MAX, -1, 1'b1);

        sent = 0;
        while (sent < RANDOM_RECTS) begin
            settle();
            steady = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 5))
                0: begin
                    kl = coord_t'($urandom);
                    kt = coord_t'($urandom);
                    kr = coord_t'($urandom);
                    kb = coord_t'($urandom);
                end
                1: begin
                    kl = ($urandom_range(0, 3) != 0) ? C_MIN : coord_t'($urandom);
                    kt = ($urandom_range(0, 3) != 0) ? C_MIN : coord_t'($urandom);
                    kr = ($urandom_range(0, 3) != 0) ? C_MAX : coord_t'($urandom);
                    kb = ($urandom_range(0, 3) != 0) ? C_MAX : coord_t'($urandom);
                end
                default: begin
                    cx = int'($urandom_range(0, 6000)) - 3000;
                    cy = int'($urandom_range(0, 6000)) - 3000;
                    w  = $urandom_range(0, 600);
                    h  = $urandom_range(0, 600);
                    kl = coord_t'(cx - w / 2);
                    kr = coord_t'(cx + w / 2);
                    kt = coord_t'(cy - h / 2);
                    kb = coord_t'(cy + h / 2);
                end
            endcase
            if ($urandom_range(0, 3) == 0) begin
                sw = kl;
                kl = kr;
                kr = sw;
            end
            if ($urandom_range(0, 3) == 0) begin
                sw = kt;
                kt = kb;
                kb = sw;
            end
            configure(kl, kt, kr, kb, t_op_mode'($urandom_range(0, 1)));
            n = $urandom_range(10, 40);
            repeat (n) begin
                send_rect(pick_coord(kl, kr), pick_coord(kt, kb),
                          pick_coord(kl, kr), pick_coord(kt, kb),
                          $urandom_range(0, 2) == 0);
                sent++;
            end
        end

        steady = 1'b0;
        settle();
        if (sb.fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
